### design/tpc_pkg.sv
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int COORD_WIDTH = 32;
  // input register, multiply stage, one stage per quotient bit, output register
  localparam int NUM_STAGES  = COORD_WIDTH + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [1:0]                    count_t;

  typedef struct packed {
    logic ab;
    logic bc;
    logic ca;
  } cross_t;

  function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH:0] x);
    logic [COORD_WIDTH:0] n;
    n = x[COORD_WIDTH] ? (~x + 1'b1) : x;
    return n[COORD_WIDTH-1:0];
  endfunction

endpackage

### design/tpc_ifs.sv
`timescale 1ns / 1ps
interface tpc_tri_if;
  import tpc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tpc_cut_if;
  import tpc_pkg::*;
  logic   valid;
  logic   ready;
  count_t cut_count;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  modport source (output valid, cut_count, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, cut_count, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tpc_cfg_if;
  import tpc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t plane_z;
  modport source (output valid, plane_z, input ready);
  modport sink (input valid, plane_z, output ready);
endinterface

### design/triangle_plane_cut.sv
`timescale 1ns / 1ps
// Cuts each triangle with the plane z = plane_z and returns the cut segment.
// Fully pipelined: one triangle per cycle unless cut_out stalls. Stages:
// input register, multiply, one divider stage per quotient bit in each of
// the six interpolation lanes, output register. Each stage moves on when
// the stage after it is empty or moving, so bubbles are squeezed out and
// new requests are taken while a result waits at the output. plane_z may
// be written only while the pipeline holds no request.
module triangle_plane_cut (
  input  logic      clk,
  input  logic      rst,
  tpc_tri_if.sink   tri_in,
  tpc_cfg_if.sink   cfg,
  tpc_cut_if.source cut_out
);
  import tpc_pkg::*;
  localparam int LAST = NUM_STAGES - 1;

  coord_t pz;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pz <= '0;
    end else if (cfg.valid) begin
      pz <= cfg.plane_z;
    end
  end

  logic [NUM_STAGES-1:0] vld, en;
  always_comb begin
    en[LAST] = !vld[LAST] || cut_out.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end
  assign tri_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= tri_in.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax <= tri_in.a_x; ay <= tri_in.a_y; az <= tri_in.a_z;
      bx <= tri_in.b_x; by <= tri_in.b_y; bz <= tri_in.b_z;
      cx <= tri_in.c_x; cy <= tri_in.c_y; cz <= tri_in.c_z;
    end
  end

  cross_t cr0;
  logic   ha, hb, hc;
  always_comb begin
    ha = (pz <= az);
    hb = (pz <= bz);
    hc = (pz <= cz);
    cr0.ab = ha ^ hb;
    cr0.bc = hb ^ hc;
    cr0.ca = hc ^ ha;
  end

  cross_t fl [1:LAST-1];
  always_ff @(posedge clk) begin
    if (en[1]) fl[1] <= cr0;
    for (int k = 2; k < LAST; k++) begin
      if (en[k]) fl[k] <= fl[k-1];
    end
  end

  // lanes: AB x/y, BC x/y, CA x/y
  coord_t                 l_base [6];
  logic [COORD_WIDTH-1:0] l_quot [6];
  logic                   l_neg  [6];
  coord_t                 pt     [6];

  tpc_lane u_abx (.clk, .en, .base(ax), .tip(bx), .z_base(az), .z_tip(bz), .pz,
                  .q_base(l_base[0]), .quot(l_quot[0]), .q_neg(l_neg[0]));
  tpc_lane u_aby (.clk, .en, .base(ay), .tip(by), .z_base(az), .z_tip(bz), .pz,
                  .q_base(l_base[1]), .quot(l_quot[1]), .q_neg(l_neg[1]));
  tpc_lane u_bcx (.clk, .en, .base(bx), .tip(cx), .z_base(bz), .z_tip(cz), .pz,
                  .q_base(l_base[2]), .quot(l_quot[2]), .q_neg(l_neg[2]));
  tpc_lane u_bcy (.clk, .en, .base(by), .tip(cy), .z_base(bz), .z_tip(cz), .pz,
                  .q_base(l_base[3]), .quot(l_quot[3]), .q_neg(l_neg[3]));
  tpc_lane u_cax (.clk, .en, .base(cx), .tip(ax), .z_base(cz), .z_tip(az), .pz,
                  .q_base(l_base[4]), .quot(l_quot[4]), .q_neg(l_neg[4]));
  tpc_lane u_cay (.clk, .en, .base(cy), .tip(ay), .z_base(cz), .z_tip(az), .pz,
                  .q_base(l_base[5]), .quot(l_quot[5]), .q_neg(l_neg[5]));

  for (genvar i = 0; i < 6; i++) begin : g_pt
    assign pt[i] = l_neg[i] ? l_base[i] - l_quot[i] : l_base[i] + l_quot[i];
  end

  count_t cnt_nx;
  coord_t sx, sy, ex, ey;
  cross_t crf;
  always_comb begin
    crf    = fl[LAST-1];
    cnt_nx = 2'd0;
    sx = '0; sy = '0; ex = '0; ey = '0;
    if (crf.ab) begin
      sx = pt[0]; sy = pt[1];
      cnt_nx = 2'd1;
    end
    if (crf.bc) begin
      if (crf.ab) begin
        ex = pt[2]; ey = pt[3];
        cnt_nx = 2'd2;
      end else begin
        sx = pt[2]; sy = pt[3];
        cnt_nx = 2'd1;
      end
    end
    if (crf.ca) begin
      ex = pt[4]; ey = pt[5];
      if (pt[4] != sx || pt[5] != sy) cnt_nx = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      cut_out.cut_count <= cnt_nx;
      cut_out.start_x   <= sx;
      cut_out.start_y   <= sy;
      cut_out.end_x     <= ex;
      cut_out.end_y     <= ey;
    end
  end
  assign cut_out.valid = vld[LAST];

endmodule

### design/tpc_lane.sv
`timescale 1ns / 1ps
// One interpolation: base + (tip - base) * (pz - zb0) / (zt - zb0),
// multiply in stage 1, restoring divide one quotient bit per stage after.
module tpc_lane (
  input  logic                          clk,
  input  logic [tpc_pkg::NUM_STAGES-1:0] en,
  input  tpc_pkg::coord_t               base,
  input  tpc_pkg::coord_t               tip,
  input  tpc_pkg::coord_t               z_base,
  input  tpc_pkg::coord_t               z_tip,
  input  tpc_pkg::coord_t               pz,
  output tpc_pkg::coord_t               q_base,
  output logic [tpc_pkg::COORD_WIDTH-1:0] quot,
  output logic                          q_neg
);
  import tpc_pkg::*;
  localparam int CW = COORD_WIDTH;

  logic [CW:0] dv, num, den;
  logic [CW-1:0] m_dv, m_num;

  always_comb begin
    dv    = {tip[CW-1], tip} - {base[CW-1], base};
    num   = {pz[CW-1], pz} - {z_base[CW-1], z_base};
    den   = {z_tip[CW-1], z_tip} - {z_base[CW-1], z_base};
    m_dv  = mag(dv);
    m_num = mag(num);
  end

  logic [2*CW-1:0] s1_prod;
  logic [CW-1:0]   s1_d;
  logic            s1_neg;
  coord_t          s1_base;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod <= m_dv * m_num;
      s1_d    <= mag(den);
      s1_neg  <= dv[CW] ^ num[CW] ^ den[CW];
      s1_base <= base;
    end
  end

  // per step: remainder, and a word holding the unused dividend bits on top
  // with the quotient bits collecting at the bottom
  logic [CW-1:0] rr [CW];
  logic [CW-1:0] ww [CW];
  logic [CW-1:0] dd [CW];
  logic          ng [CW];
  coord_t        bs [CW];

  for (genvar j = 0; j < CW; j++) begin : g_step
    logic [CW-1:0] r_in, w_in, d_in, r_nx;
    logic          n_in, ge;
    coord_t        b_in;
    logic [CW:0]   t, t_sub;

    always_comb begin
      if (j == 0) begin
        r_in = s1_prod[2*CW-1:CW];
        w_in = s1_prod[CW-1:0];
        d_in = s1_d;
        n_in = s1_neg;
        b_in = s1_base;
      end else begin
        r_in = rr[j-1];
        w_in = ww[j-1];
        d_in = dd[j-1];
        n_in = ng[j-1];
        b_in = bs[j-1];
      end
      t     = {r_in, w_in[CW-1]};
      t_sub = t - {1'b0, d_in};
      ge    = (t >= {1'b0, d_in});
      r_nx  = ge ? t_sub[CW-1:0] : t[CW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        rr[j] <= r_nx;
        ww[j] <= {w_in[CW-2:0], ge};
        dd[j] <= d_in;
        ng[j] <= n_in;
        bs[j] <= b_in;
      end
    end
  end

  assign quot   = ww[CW-1];
  assign q_neg  = ng[CW-1];
  assign q_base = bs[CW-1];

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tpc_pkg::*;

  typedef struct {
    count_t cnt;
    coord_t sx, sy, ex, ey;
  } cut_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  tpc_tri_if tri_ch();
  tpc_cfg_if cfg_ch();
  tpc_cut_if cut_ch();

  triangle_plane_cut dut (
    .clk(clk), .rst(rst), .tri_in(tri_ch.sink), .cfg(cfg_ch.sink), .cut_out(cut_ch.source)
  );

  cut_t   cuts_pending[$];
  int     errors = 0;
  int     cycles = 0;
  bit     quiet = 1'b0;
  coord_t plane;

  initial begin
    tri_ch.valid = 1'b0;
    tri_ch.a_x = '0; tri_ch.a_y = '0; tri_ch.a_z = '0;
    tri_ch.b_x = '0; tri_ch.b_y = '0; tri_ch.b_z = '0;
    tri_ch.c_x = '0; tri_ch.c_y = '0; tri_ch.c_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.plane_z = '0;
    cut_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // a + (b-a)*num/den truncated toward zero, exact in 128 bits
  function automatic coord_t lerp(coord_t a, coord_t b, logic signed [63:0] num,
                                  logic signed [63:0] den);
    logic signed [127:0] p;
    logic signed [127:0] q;
    logic signed [63:0]  dv;
    dv = 64'(b) - 64'(a);
    p = 128'(dv) * 128'(num);
    q = (den == 0) ? 128'sd0 : p / 128'(den);
    return coord_t'(128'(a) + q);
  endfunction

  function automatic cut_t cut_triangle(coord_t v[9], coord_t pz);
    cut_t r;
    bit   up[3];
    coord_t px, py;
    r = '{2'd0, '0, '0, '0, '0};
    for (int i = 0; i < 3; i++) up[i] = (pz <= v[3*i+2]);
    for (int e = 0; e < 3; e++) begin
      int s, t;
      s = e; t = (e + 1) % 3;
      if (up[s] != up[t]) begin
        px = lerp(v[3*s], v[3*t], 64'(pz) - 64'(v[3*s+2]), 64'(v[3*t+2]) - 64'(v[3*s+2]));
        py = lerp(v[3*s+1], v[3*t+1], 64'(pz) - 64'(v[3*s+2]),
                  64'(v[3*t+2]) - 64'(v[3*s+2]));
        if (e == 2) begin
          r.ex = px; r.ey = py;
          if (px != r.sx || py != r.sy) r.cnt = 2'd2;
        end else if (r.cnt > 0) begin
          r.ex = px; r.ey = py; r.cnt = 2'd2;
        end else begin
          r.sx = px; r.sy = py; r.cnt = 2'd1;
        end
      end
    end
    return r;
  endfunction

  // result checker with random stall
  initial begin
    int stall;
    cut_t x;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cut_ch.valid && cut_ch.ready) begin
        if (cuts_pending.size() == 0) begin
          $display("%0t unexpected result count=%0d", $time, cut_ch.cut_count);
          errors++;
        end else begin
          x = cuts_pending.pop_front();
          if (x.cnt !== cut_ch.cut_count || x.sx !== cut_ch.start_x ||
              x.sy !== cut_ch.start_y || x.ex !== cut_ch.end_x || x.ey !== cut_ch.end_y) begin
            $display("%0t mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d", $time,
                     x.cnt, x.sx, x.sy, x.ex, x.ey, cut_ch.cut_count, cut_ch.start_x,
                     cut_ch.start_y, cut_ch.end_x, cut_ch.end_y);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        cut_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        cut_ch.ready <= 1'b0;
      end else begin
        cut_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays up between back-to-back requests; idling and draining drop it
  task automatic send_triangle(coord_t v[9]);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      tri_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    tri_ch.valid <= 1'b1;
    tri_ch.a_x <= v[0]; tri_ch.a_y <= v[1]; tri_ch.a_z <= v[2];
    tri_ch.b_x <= v[3]; tri_ch.b_y <= v[4]; tri_ch.b_z <= v[5];
    tri_ch.c_x <= v[6]; tri_ch.c_y <= v[7]; tri_ch.c_z <= v[8];
    do @(posedge clk); while (!tri_ch.ready);
    cuts_pending = {cuts_pending, cut_triangle(v, plane)};
  endtask

  task automatic drain_cuts();
    tri_ch.valid <= 1'b0;
    while (cuts_pending.size() > 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  task automatic set_plane(coord_t z);
    drain_cuts();
    cfg_ch.valid <= 1'b1;
    cfg_ch.plane_z <= z;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    plane = z;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
      2: return plane + coord_t'(int'($urandom_range(0, 6)) - 3);
      default: return coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t v[9];
    coord_t mx, mn;
    mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    set_plane('0);
    v = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; send_triangle(v);                // no cut
    v = '{0, 0, -10, 100, 50, 10, 0, 100, 10}; send_triangle(v);       // segment
    v = '{5, 7, 0, 100, 50, -10, 0, 100, -10}; send_triangle(v);       // vertex touch
    v = '{mx, mn, mn, mn, mx, mx, mx, mx, mx}; send_triangle(v);       // extremes
    v = '{mn, mx, mx, mx, mn, mn, mn, mn, mn}; send_triangle(v);
    v = '{3, 0, -1, 4, 0, 2, 3, 1, 2}; send_triangle(v);               // rounding coincidence
    v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; send_triangle(v);
    set_plane(mx);
    v = '{mn, mn, mn, mx, mx, mx, 0, 0, 0}; send_triangle(v);
    set_plane(mn);
    v = '{mn, mn, mn, mx, mx, mx, 0, 0, 0}; send_triangle(v);
    v = '{1, 1, mn, 2, 2, mn, 3, 3, mn}; send_triangle(v);
  endtask

  task automatic test_random(int n, bit last);
    coord_t v[9];
    int mode;
    for (int i = 0; i < n; i++) begin
      if (i % 250 == 0) begin
        case ($urandom_range(0, 3))
          0: set_plane(coord_t'($urandom));
          1: set_plane('0);
          default: set_plane(coord_t'(int'($urandom_range(0, 4000)) - 2000));
        endcase
      end
      quiet = last && (i > n / 2);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++)
        v[k] = (k % 3 == 2) ? rand_coord(mode == 0 ? 0 : 2 + (k & 0)) : rand_coord(mode);
      if (mode == 1)
        for (int k = 2; k < 9; k += 3) v[k] = rand_coord(1);
      send_triangle(v);
      if (i == n / 3) drain_cuts(); // sender holds off until results are all back
    end
  endtask

  initial begin
    plane = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1000, 1'b0);
    test_random(1000, 1'b1);
    drain_cuts();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### files.f
design/tpc_pkg.sv
design/tpc_ifs.sv
design/tpc_lane.sv
design/triangle_plane_cut.sv
tb/tb.sv
